[rtl/mbce_pkg.sv]
`timescale 1ns / 1ps

package mbce_pkg;

	// Frame size bounds and register widths.
	localparam int DimW = 13;
	localparam logic [DimW-1:0] MAX_WIDTH  = 13'd4096;
	localparam logic [DimW-1:0] MAX_HEIGHT = 13'd4096;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ROW_WIDTH      = 3'd0;
	localparam logic [2:0] REG_ROW_COUNT      = 3'd1;
	localparam logic [2:0] REG_BYTES_PER_PIX  = 3'd2;
	localparam logic [2:0] REG_USE_MAP        = 3'd3;
	localparam logic [2:0] REG_KEY_ENABLE     = 3'd4;
	localparam logic [2:0] REG_KEY_BIT        = 3'd5;
	localparam logic [2:0] REG_COLOR_ZERO     = 3'd6;
	localparam logic [2:0] REG_COLOR_ONE      = 3'd7;

	// Configuration registers as seen by the front and back parts.
	typedef struct packed {
		logic [DimW-1:0] row_width;
		logic [DimW-1:0] row_count;
		logic [2:0]      bytes_per_pixel;
		logic            use_map;
		logic            key_enable;
		logic            key_bit;
		logic [31:0]     color_for_zero;
		logic [31:0]     color_for_one;
	} cfg_t;

	// One classified source byte, waiting to be expanded.
	typedef struct packed {
		logic [7:0] source_byte;
		logic [3:0] pixel_count;
		logic       row_done;
		logic       frame_done;
	} entry_t;

endpackage

[rtl/mbce_fifo.sv]
`timescale 1ns / 1ps

module mbce_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbce_pkg::entry_t push_data,
	input  logic            pop,
	output mbce_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	mbce_pkg::entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/mbce_front.sv]
`timescale 1ns / 1ps

module mbce_front (
	input  logic             clk,
	input  logic             arst_n,
	input  mbce_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       source_byte,
	input  logic             queue_full,
	output logic             push,
	output mbce_pkg::entry_t push_data
);

	logic [mbce_pkg::DimW-1:0] col_q;
	logic [mbce_pkg::DimW-1:0] row_q;
	logic [mbce_pkg::DimW-1:0] width;
	logic [mbce_pkg::DimW-1:0] count;
	logic [mbce_pkg::DimW-1:0] col;
	logic [mbce_pkg::DimW-1:0] remain;
	logic [mbce_pkg::DimW-1:0] row_next;
	logic                      row_done;
	logic                      frame_done;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Clamp the frame size to its legal range.
	always_comb begin
		if (cfg.row_width == '0) begin
			width = mbce_pkg::DimW'(1);
		end else if (cfg.row_width > mbce_pkg::MAX_WIDTH) begin
			width = mbce_pkg::MAX_WIDTH;
		end else begin
			width = cfg.row_width;
		end
		if (cfg.row_count == '0) begin
			count = mbce_pkg::DimW'(1);
		end else if (cfg.row_count > mbce_pkg::MAX_HEIGHT) begin
			count = mbce_pkg::MAX_HEIGHT;
		end else begin
			count = cfg.row_count;
		end
	end

	// Classify the byte: how many pixels it yields and whether it ends a row or frame.
	always_comb begin
		col        = (col_q >= width) ? '0 : col_q;
		remain     = width - col;
		row_done   = (remain <= mbce_pkg::DimW'(8));
		row_next   = row_q + mbce_pkg::DimW'(1);
		frame_done = row_done && (row_next >= count);
		push_data.source_byte = source_byte;
		push_data.pixel_count = row_done ? remain[3:0] : 4'd8;
		push_data.row_done    = row_done;
		push_data.frame_done  = frame_done;
	end

	// Column and row position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_done) begin
				col_q <= '0;
				row_q <= frame_done ? '0 : row_next;
			end else begin
				col_q <= col + mbce_pkg::DimW'(8);
			end
		end
	end

endmodule

[rtl/mbce_back.sv]
`timescale 1ns / 1ps

module mbce_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mbce_pkg::cfg_t   cfg,
	input  mbce_pkg::entry_t head,
	input  logic             queue_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      pixel_value,
	output logic             write_enable,
	output logic             byte_last,
	output logic             row_end,
	output logic             frame_end
);

	logic [2:0]  pix_idx_q;
	logic        out_valid_q;
	logic [31:0] pixel_value_q;
	logic        write_enable_q;
	logic        byte_last_q;
	logic        row_end_q;
	logic        frame_end_q;

	logic        load;
	logic        bit_val;
	logic        last;
	logic [2:0]  bpp;
	logic [31:0] word;
	logic [31:0] pix;

	assign load = !queue_empty && (!out_valid_q || out_ready);
	assign last = ({1'b0, pix_idx_q} + 4'd1) == head.pixel_count;
	assign pop  = load && last;

	// Select the current source bit, MSB first, and form its pixel.
	always_comb begin
		bit_val = head.source_byte[3'd7 - pix_idx_q];
		if (cfg.bytes_per_pixel == 3'd0) begin
			bpp = 3'd1;
		end else if (cfg.bytes_per_pixel > 3'd4) begin
			bpp = 3'd4;
		end else begin
			bpp = cfg.bytes_per_pixel;
		end
		word = bit_val ? cfg.color_for_one : cfg.color_for_zero;
		if (!cfg.use_map && bpp == 3'd1) begin
			pix = {31'd0, bit_val};
		end else begin
			case (bpp)
				3'd1:    pix = {24'd0, word[7:0]};
				3'd2:    pix = {16'd0, word[15:0]};
				3'd3:    pix = {8'd0, word[23:0]};
				default: pix = word;
			endcase
		end
	end

	// Pixel index within the head byte, and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pix_idx_q   <= last ? 3'd0 : pix_idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_value_q  <= pix;
			write_enable_q <= !(cfg.key_enable && (bit_val == cfg.key_bit));
			byte_last_q    <= last;
			row_end_q      <= last && head.row_done;
			frame_end_q    <= last && head.frame_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_value  = pixel_value_q;
	assign write_enable = write_enable_q;
	assign byte_last    = byte_last_q;
	assign row_end      = row_end_q;
	assign frame_end    = frame_end_q;

endmodule

[rtl/mono_bitmap_color_expand.sv]
`timescale 1ns / 1ps

// Monochrome color expansion: each 1-bit-per-pixel source byte (leftmost pixel in
// bit 7) becomes 8 destination pixels, or fewer at the end of a row, one pixel per
// clock on the output stream while m_axis_tready holds and a byte is queued; each
// byte yields 1 to 8 pixels (8 inside a row) via the back part's one-pixel
// selector and output register. The front part takes a new byte every cycle while
// its two-entry queue has room, so bytes queue up during expansion; an accepted
// byte passes through the queue and the output register. Configuration is written
// through cfg_wr_en/cfg_index/cfg_data, by the user only while idle (not enforced).
module mono_bitmap_color_expand (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] pixel_value
	output logic [2:0]  m_axis_tuser,   // [0] write_enable, [1] byte_last, [2] row_end
	output logic        m_axis_tlast    // frame_end
);

	mbce_pkg::cfg_t   cfg_q;
	mbce_pkg::entry_t push_data;
	mbce_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width       <= mbce_pkg::DimW'(1);
			cfg_q.row_count       <= mbce_pkg::DimW'(1);
			cfg_q.bytes_per_pixel <= 3'd1;
			cfg_q.use_map         <= 1'b0;
			cfg_q.key_enable      <= 1'b0;
			cfg_q.key_bit         <= 1'b0;
			cfg_q.color_for_zero  <= '0;
			cfg_q.color_for_one   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbce_pkg::REG_ROW_WIDTH:     cfg_q.row_width <= cfg_data[mbce_pkg::DimW-1:0];
				mbce_pkg::REG_ROW_COUNT:     cfg_q.row_count <= cfg_data[mbce_pkg::DimW-1:0];
				mbce_pkg::REG_BYTES_PER_PIX: cfg_q.bytes_per_pixel <= cfg_data[2:0];
				mbce_pkg::REG_USE_MAP:       cfg_q.use_map <= cfg_data[0];
				mbce_pkg::REG_KEY_ENABLE:    cfg_q.key_enable <= cfg_data[0];
				mbce_pkg::REG_KEY_BIT:       cfg_q.key_bit <= cfg_data[0];
				mbce_pkg::REG_COLOR_ZERO:    cfg_q.color_for_zero <= cfg_data;
				mbce_pkg::REG_COLOR_ONE:     cfg_q.color_for_one <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front part: accepts and classifies source bytes.
	mbce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.source_byte (s_axis_tdata),
		.queue_full  (queue_full),
		.push        (push),
		.push_data   (push_data)
	);

	// Queue between the two parts.
	mbce_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// Back part: expands one pixel per cycle while the output accepts and the queue is not empty.
	mbce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.queue_empty  (queue_empty),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pixel_value  (m_axis_tdata),
		.write_enable (m_axis_tuser[0]),
		.byte_last    (m_axis_tuser[1]),
		.row_end      (m_axis_tuser[2]),
		.frame_end    (m_axis_tlast)
	);

	// A frame end is always also a row end.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
		else $error("frame end without row end");

	// A row end always closes a source byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
		else $error("row end without byte end");

	// The back part never retires an entry the queue does not hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("pop from empty queue");

	// The front part never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("push into full queue");

endmodule
